[design/dq_pkg.sv]
package dq_pkg;

    // payload widths of the request and response channels
    localparam int DATA_W   = 32;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;

    // operation codes carried in the func field
    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH_FRONT = 2'd0,
        FUNC_PUSH_REAR  = 2'd1,
        FUNC_POP_FRONT  = 2'd2,
        FUNC_POP_REAR   = 2'd3
    } t_func;

    // response status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_LOAD = 2'd2
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic commit;
        logic load_pop;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
        logic needs_load;
    } t_dp_sts;

endpackage

[design/dq_if.sv]
interface dq_req_if import dq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] push_value;

    modport source (output valid, output func, output push_value, input ready);
    modport sink   (input valid, input func, input push_value, output ready);
endinterface

interface dq_rsp_if import dq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] pop_value;
    logic [STATUS_W-1:0]      status;
    logic                     now_empty;
    logic                     now_full;

    modport source (output valid, output pop_value, output status, output now_empty,
                    output now_full, input ready);
    modport sink   (input valid, input pop_value, input status, input now_empty,
                    input now_full, output ready);
endinterface

[design/dq_ctrl.sv]
module dq_ctrl import dq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    output logic    o_req_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.needs_load ? ST_LOAD : ST_IDLE;
                end
            end
            ST_LOAD: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_req_ready     = 1'b0;
        o_cmd.capture   = 1'b0;
        o_cmd.commit    = 1'b0;
        o_cmd.load_pop  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_req_ready   = 1'b1;
                o_cmd.capture = i_req_valid;
            end
            ST_EXEC: begin
                o_cmd.commit = i_sts.out_free;
            end
            ST_LOAD: begin
                o_cmd.load_pop = 1'b1;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

    // a read result is only loaded right after the commit that issued the read
    a_load_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_pop |-> $past(o_cmd.commit) && $past(i_sts.needs_load))
        else $error("load without preceding pop commit");

    // a captured request is always followed by the execute state
    a_capture_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> r_state == ST_EXEC)
        else $error("capture did not enter execute");

    // commit overlaps neither load nor capture
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.commit && o_cmd.load_pop) && !(o_cmd.capture && o_cmd.commit))
        else $error("overlapping datapath commands");

endmodule

[design/dq_datapath.sv]
module dq_datapath import dq_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_sts                  o_sts,
    input  logic [FUNC_W-1:0]        i_func,
    input  logic signed [DATA_W-1:0] i_push_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_pop_value,
    output logic [STATUS_W-1:0]      o_status,
    output logic                     o_now_empty,
    output logic                     o_now_full
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = IDX_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(DEPTH);

    // slot storage
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // captured request
    t_func                    r_func;
    logic signed [DATA_W-1:0] r_value;

    // ring pointers
    logic [IDX_W-1:0] r_head;
    logic [IDX_W-1:0] n_head;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // output register
    logic                     r_out_valid;
    logic                     n_out_valid;
    logic signed [DATA_W-1:0] r_out_data;
    t_status                  r_out_status;
    logic                     r_out_empty;
    logic                     r_out_full;

    logic             is_pop;
    logic             is_front;
    logic             empty;
    logic             full;
    logic [IDX_W-1:0] head_prev;
    logic [IDX_W-1:0] head_next;
    logic [SUM_W-1:0] offset;
    logic [SUM_W-1:0] sum;
    logic [IDX_W-1:0] rear_pos;
    logic [IDX_W-1:0] addr;
    logic             wr_en;
    logic             rd_en;
    logic             load_direct;

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func  <= t_func'(i_func);
            r_value <= i_push_value;
        end
    end

    // decode and address arithmetic
    always_comb begin
        is_pop    = (r_func == FUNC_POP_FRONT) || (r_func == FUNC_POP_REAR);
        is_front  = (r_func == FUNC_PUSH_FRONT) || (r_func == FUNC_POP_FRONT);
        empty     = (r_count == '0);
        full      = (r_count == FULL_CNT);
        head_prev = (r_head == '0) ? LAST_IDX : r_head - IDX_W'(1);
        head_next = (r_head == LAST_IDX) ? '0 : r_head + IDX_W'(1);
        offset    = is_pop ? SUM_W'(r_count) - SUM_W'(1) : SUM_W'(r_count);
        sum       = {1'b0, r_head} + offset;
        rear_pos  = (sum >= DEPTH_S) ? IDX_W'(sum - DEPTH_S) : IDX_W'(sum);
        if (is_front) begin
            addr = is_pop ? r_head : head_prev;
        end else begin
            addr = rear_pos;
        end
        wr_en       = i_cmd.commit && !is_pop && !full;
        rd_en       = i_cmd.commit && is_pop && !empty;
        load_direct = i_cmd.commit && !(is_pop && !empty);
    end

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[addr] <= r_value;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[addr];
        end
    end

    // pointer update
    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (wr_en) begin
            n_count = r_count + CNT_W'(1);
            if (is_front) begin
                n_head = head_prev;
            end
        end else if (rd_en) begin
            n_count = r_count - CNT_W'(1);
            if (is_front) begin
                n_head = head_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // output register valid
    always_comb begin
        if (load_direct || i_cmd.load_pop) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (load_direct) begin
            if (is_pop) begin
                r_out_data   <= '1;
                r_out_status <= STATUS_EMPTY;
            end else begin
                r_out_data   <= '0;
                r_out_status <= full ? STATUS_FULL : STATUS_OK;
            end
        end else if (i_cmd.load_pop) begin
            r_out_data   <= r_rd_data;
            r_out_status <= STATUS_OK;
        end
        if (load_direct || i_cmd.load_pop) begin
            r_out_empty <= (n_count == '0);
            r_out_full  <= (n_count == FULL_CNT);
        end
    end

    assign o_sts.out_free   = !r_out_valid || i_out_ready;
    assign o_sts.needs_load = is_pop && !empty;
    assign o_out_valid      = r_out_valid;
    assign o_pop_value      = r_out_data;
    assign o_status         = r_out_status;
    assign o_now_empty      = r_out_empty;
    assign o_now_full       = r_out_full;

    // fill level and head stay in range
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= FULL_CNT) && (r_head <= LAST_IDX))
        else $error("pointer out of range");

    // a pushed entry grows the count by exactly one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en |=> r_count == $past(r_count) + CNT_W'(1)) )
        else $error("push did not grow the count");

    // an empty pop response always carries all ones and the empty flag
    a_empty_pop_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == STATUS_EMPTY) |-> (r_out_data == '1) && r_out_empty)
        else $error("empty pop response malformed");

    // output register is never reloaded while a response still waits
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !(load_direct || i_cmd.load_pop))
        else $error("response overwritten");

endmodule

[design/double_ended_queue_core.sv]
// Bounded double-ended queue of signed 32-bit values held in a ring buffer of
// DEPTH slots. Each request is push front, push rear, pop front or pop rear and
// yields exactly one response with the popped value (-1 on a pop from an empty
// queue, 0 on pushes), a status (ok, pop from empty, push into full dropped) and
// the empty and full flags after the operation. One request is worked on at a
// time: a push or an error goes through accept and execute, and its response
// is registered when execute ends; a successful pop goes through accept,
// execute and load, and its response is registered when load ends, because
// the slot memory has a registered read port. A finished response waits in
// an output register, so the next request is accepted while it is still
// pending; that request then stalls in execute until the pending response is
// taken. Slots need no clearing after reset; only filled slots are ever read.
module double_ended_queue_core import dq_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dq_req_if.sink   i_req,
    dq_rsp_if.source o_rsp
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencing of each request
    dq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // storage, pointers and response register
    dq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_func       (i_req.func),
        .i_push_value (i_req.push_value),
        .o_out_valid  (o_rsp.valid),
        .i_out_ready  (o_rsp.ready),
        .o_pop_value  (o_rsp.pop_value),
        .o_status     (o_rsp.status),
        .o_now_empty  (o_rsp.now_empty),
        .o_now_full   (o_rsp.now_full)
    );

endmodule
